[sv/tofw_pkg.sv]
// ============================================================================
// tofw_pkg
// Shared widths, register indexes and limits for the TOF time-walk core.
// ============================================================================
`default_nettype none

package tofw_pkg;

    // Inverse root: R = floor(2^18 / sqrt(d)), 19 bits, one bit per stage
    localparam int ROOT_W  = 19;
    localparam int ACC_W   = 56;   // width of R^2*d trial accumulator
    localparam int DIV_NW  = 20;   // |d| * 16
    localparam int UNIT_LAT = ROOT_W;  // stages in the root and divider units

    localparam logic [ACC_W-1:0] ROOT_LIM = ACC_W'(64'h10_0000_0000); // 2^36

    localparam int SUM_W = 50;
    localparam logic signed [SUM_W-1:0] TIME_MAX = SUM_W'(64'sh7F_FFFF_FFFF);
    localparam logic signed [SUM_W-1:0] TIME_MIN = -SUM_W'(64'sh80_0000_0000);

    typedef enum logic [2:0] {
        REG_PEDESTAL   = 3'd0,
        REG_GAIN       = 3'd1,
        REG_TIME_SCALE = 3'd2,
        REG_WALK_C0    = 3'd3,
        REG_WALK_C1    = 3'd4,
        REG_WALK_C2    = 3'd5,
        REG_WALK_C3    = 3'd6,
        REG_WALK_TERMS = 3'd7
    } reg_idx_t;

    // Control carried alongside the data through the arithmetic units
    typedef struct packed {
        logic        good;
        logic        low;     // charge not above pedestal
        logic        neg;     // d negative
        logic [2:0]  nterms;
        logic [36:0] tprod;   // tdc * time_scale
    } side_t;

endpackage

`default_nettype wire

[sv/tof_hit_time_walk_correction_core.sv]
// ============================================================================
// tof_hit_time_walk_correction_core
// PMT hit calibration: photoelectrons and walk-corrected time per hit.
// ============================================================================
// One hit enters per clock and one result leaves per clock when the output
// is not stalled. The pipe is a decode register, the 19-stage inverse-root
// unit (one bit of R = 2^18/sqrt(d) per stage, run in parallel with a
// 19-stage restoring divider for the photoelectron count), three multiply
// stages for the walk powers and terms and one sum/saturate stage.
// The whole pipe advances together; when the output is stalled the pipe
// holds, so no transaction is dropped or repeated.
// Configuration writes are always accepted (cfg_ready tied high) and must be
// made while no hit is in flight.
`default_nettype none

module tof_hit_time_walk_correction_core
    import tofw_pkg::*;
#(
    parameter int WALK_TERMS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: adc_count[11:0], tdc_count[32:12], pmt_index[34:33], slab_index[41:35]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    // s_tuser: adc_present[0], tdc_present[1]
    input  wire logic [1:0]  s_tuser,
    // m_tdata: photoelectrons[12:0], corrected_time[52:13]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,
    // m_tuser: hit_good[0], charge_not_above_pedestal[1]
    output logic      [1:0]  m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam int LAST = UNIT_LAT + 4;

    // ---------------- configuration registers ----------------
    logic        [15:0] pedestal_reg, gain_reg, scale_reg;
    logic signed [23:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic        [2:0]  terms_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pedestal_reg <= 16'd0;
            gain_reg     <= 16'd256;
            scale_reg    <= 16'd6400;
            c0_reg       <= '0;
            c1_reg       <= '0;
            c2_reg       <= '0;
            c3_reg       <= '0;
            terms_reg    <= 3'd0;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_PEDESTAL:   pedestal_reg <= cfg_data[15:0];
                REG_GAIN:       gain_reg     <= cfg_data[15:0];
                REG_TIME_SCALE: scale_reg    <= cfg_data[15:0];
                REG_WALK_C0:    c0_reg       <= cfg_data;
                REG_WALK_C1:    c1_reg       <= cfg_data;
                REG_WALK_C2:    c2_reg       <= cfg_data;
                REG_WALK_C3:    c3_reg       <= cfg_data;
                REG_WALK_TERMS: terms_reg    <= cfg_data[2:0];
                default:        ;
            endcase
        end
    end

    // ---------------- pipe control ----------------
    logic v_reg [0:LAST];
    logic adv;

    assign adv      = !v_reg[LAST] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
                v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= s_tvalid;
            for (int k = 1; k <= LAST; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // ---------------- stage 0: decode ----------------
    logic [11:0]        in_adc;
    logic [20:0]        in_tdc;
    logic signed [16:0] d_in;
    logic [16:0]        mag_in;
    logic [2:0]         nterms_in;
    logic [15:0]        gain_eff;
    side_t              side_in;
    side_t              side_reg [0:UNIT_LAT];
    logic [15:0]        mag_reg;

    assign in_adc = s_tdata[11:0];
    assign in_tdc = s_tdata[32:12];
    assign d_in   = $signed({1'b0, in_adc, 4'b0000}) - $signed({1'b0, pedestal_reg});
    assign mag_in = d_in[16] ? 17'(-d_in) : 17'(d_in);
    assign nterms_in = (terms_reg > 3'(WALK_TERMS)) ? 3'(WALK_TERMS) : terms_reg;
    assign gain_eff  = (gain_reg < 16'd256) ? 16'd256 : gain_reg;

    always_comb
    begin
        side_in.good   = s_tuser[0] && s_tuser[1] && !s_tdata[34] && !s_tdata[41];
        side_in.low    = d_in[16] || (d_in == '0);
        side_in.neg    = d_in[16];
        side_in.nterms = nterms_in;
        side_in.tprod  = 37'(in_tdc) * 37'(scale_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            mag_reg     <= mag_in[15:0];
            for (int k = 1; k <= UNIT_LAT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // ---------------- inverse root and divider ----------------
    logic [ROOT_W-1:0] root_r, div_q;

    tofw_isqrt u_isqrt (
        .clk (clk),
        .en  (adv),
        .d   (mag_reg),
        .r   (root_r)
    );

    tofw_div u_div (
        .clk (clk),
        .en  (adv),
        .num ({mag_reg, 4'b0000}),
        .den (gain_eff),
        .q   (div_q)
    );

    // ---------------- power / term multiply stages ----------------
    side_t              side20_reg, side21_reg, side22_reg;
    logic [ROOT_W-1:0]  r20_reg;
    logic [20:0]        p2_20_reg;
    logic [22:0]        p3_21_reg;
    logic signed [12:0] pe20_reg, pe21_reg, pe22_reg;
    logic signed [43:0] prod1_20_reg, prod1_21_reg, prod1_22_reg;
    logic signed [45:0] prod2_21_reg, prod2_22_reg;
    logic signed [47:0] prod3_22_reg;
    logic [37:0]        rr_full;
    logic [39:0]        p2r_full;

    assign rr_full  = {19'd0, root_r} * {19'd0, root_r};
    assign p2r_full = {19'd0, p2_20_reg} * {21'd0, r20_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 20
            side20_reg   <= side_reg[UNIT_LAT];
            r20_reg      <= root_r;
            p2_20_reg    <= rr_full[36:16];
            prod1_20_reg <= c1_reg * $signed({1'b0, root_r});
            pe20_reg     <= side_reg[UNIT_LAT].neg ? -$signed(div_q[12:0])
                                                   : $signed(div_q[12:0]);
            // stage 21
            side21_reg   <= side20_reg;
            p3_21_reg    <= p2r_full[38:16];
            prod2_21_reg <= c2_reg * $signed({1'b0, p2_20_reg});
            prod1_21_reg <= prod1_20_reg;
            pe21_reg     <= pe20_reg;
            // stage 22
            side22_reg   <= side21_reg;
            prod3_22_reg <= c3_reg * $signed({1'b0, p3_21_reg});
            prod2_22_reg <= prod2_21_reg;
            prod1_22_reg <= prod1_21_reg;
            pe22_reg     <= pe21_reg;
        end
    end

    // ---------------- sum, saturate, output ----------------
    logic signed [SUM_W-1:0] t_sum, t_sat;
    logic                    use0, use1, use2, use3;
    logic signed [39:0]      time_reg;
    logic signed [12:0]      pe_reg;
    logic                    good_reg, low_reg;

    always_comb
    begin
        use0  = side22_reg.nterms >= 3'd1;
        use1  = !side22_reg.low && side22_reg.nterms >= 3'd2;
        use2  = !side22_reg.low && side22_reg.nterms >= 3'd3;
        use3  = !side22_reg.low && side22_reg.nterms >= 3'd4;
        t_sum = $signed({13'd0, side22_reg.tprod})
              - (use0 ? SUM_W'(c0_reg) : '0)
              - (use1 ? SUM_W'(prod1_22_reg >>> 16) : '0)
              - (use2 ? SUM_W'(prod2_22_reg >>> 16) : '0)
              - (use3 ? SUM_W'(prod3_22_reg >>> 16) : '0);
        if (t_sum > TIME_MAX)
            t_sat = TIME_MAX;
        else if (t_sum < TIME_MIN)
            t_sat = TIME_MIN;
        else
            t_sat = t_sum;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            good_reg <= side22_reg.good;
            low_reg  <= side22_reg.good && side22_reg.low;
            pe_reg   <= side22_reg.good ? pe22_reg : '0;
            time_reg <= side22_reg.good ? t_sat[39:0] : '0;
        end
    end

    assign m_tvalid = v_reg[LAST];
    assign m_tdata  = {3'd0, time_reg, pe_reg};
    assign m_tuser  = {low_reg, good_reg};

    // ---------------- assertions ----------------
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !good_reg) |-> (pe_reg == '0 && time_reg == '0 && !low_reg))
        else $error("bad hit carries nonzero result");

    a_low_pe: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && low_reg) |-> (pe_reg[12] || pe_reg == '0))
        else $error("positive photoelectrons below pedestal");

    a_high_pe: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && good_reg && !low_reg) |-> !pe_reg[12])
        else $error("negative photoelectrons above pedestal");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output stall");

endmodule

`default_nettype wire

[sv/tofw_isqrt.sv]
// ============================================================================
// tofw_isqrt
// Pipelined inverse square root, one result bit per stage, add/shift only.
// ============================================================================
`default_nettype none

module tofw_isqrt
    import tofw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [15:0]       d,
    output logic      [ROOT_W-1:0] r
);

    // a = R^2*d, b = R*d, tracked incrementally
    logic [ACC_W-1:0]  a_reg [0:ROOT_W-1];
    logic [ACC_W-1:0]  b_reg [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_reg [0:ROOT_W-1];
    logic [15:0]       d_reg [0:ROOT_W-1];

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++) begin : g_stage
            localparam int K = ROOT_W - 1 - i;
            logic [ACC_W-1:0]  pa, pb, a_try;
            logic [ROOT_W-1:0] pr;
            logic [15:0]       pd;
            logic              take;

            if (i == 0) begin : g_first
                assign pa = '0;
                assign pb = '0;
                assign pr = '0;
                assign pd = d;
            end else begin : g_next
                assign pa = a_reg[i-1];
                assign pb = b_reg[i-1];
                assign pr = r_reg[i-1];
                assign pd = d_reg[i-1];
            end

            assign a_try = pa + (pb << (K + 1)) + ({{(ACC_W-16){1'b0}}, pd} << (2 * K));
            assign take  = (a_try <= ROOT_LIM);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[i] <= take ? a_try : pa;
                    b_reg[i] <= take ? pb + ({{(ACC_W-16){1'b0}}, pd} << K) : pb;
                    r_reg[i] <= pr | (ROOT_W'(take) << K);
                    d_reg[i] <= pd;
                end
            end
        end
    endgenerate

    assign r = r_reg[ROOT_W-1];

endmodule

`default_nettype wire

[sv/tofw_div.sv]
// ============================================================================
// tofw_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
`default_nettype none

module tofw_div
    import tofw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [DIV_NW-1:0] num,
    input  wire logic [15:0]       den,
    output logic      [ROOT_W-1:0] q
);

    logic [DIV_NW-1:0] rem_reg [0:ROOT_W-1];
    logic [ROOT_W-1:0] q_reg   [0:ROOT_W-1];
    logic [15:0]       den_reg [0:ROOT_W-1];

    genvar i;
    generate
        for (i = 0; i < ROOT_W; i++) begin : g_stage
            localparam int K = ROOT_W - 1 - i;
            logic [DIV_NW-1:0] prem;
            logic [ROOT_W-1:0] pq;
            logic [15:0]       pden;
            logic [35:0]       sub;
            logic              fits;

            if (i == 0) begin : g_first
                assign prem = num;
                assign pq   = '0;
                assign pden = den;
            end else begin : g_next
                assign prem = rem_reg[i-1];
                assign pq   = q_reg[i-1];
                assign pden = den_reg[i-1];
            end

            assign sub  = {20'd0, pden} << K;
            assign fits = ({16'd0, prem} >= sub);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= fits ? prem - sub[DIV_NW-1:0] : prem;
                    q_reg[i]   <= pq | (ROOT_W'(fits) << K);
                    den_reg[i] <= pden;
                end
            end
        end
    endgenerate

    assign q = q_reg[ROOT_W-1];

endmodule

`default_nettype wire
